// File: sv/gdfv_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and rounding helpers for the gated direction filter.
// Used by every module of the block; depends on nothing.
package gdfv_pkg;

   localparam int WORD_W   = 64;
   localparam int FIELD_W  = 16;
   localparam int MUL_A_W  = 34;
   localparam int MUL_B_W  = 32;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SQ_IN_W  = 32;
   localparam int SQ_OUT_W = 16;
   localparam int EMA_SHIFT = 16;

   localparam logic [15:0] GAIN_RESET = 16'd9830;
   localparam logic [7:0]  REJECT_MAX = 8'd255;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_ACC  = 6'b000100,
      ST_SQRT = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      GRP_DOT = 3'd0,
      GRP_EMA = 3'd1,
      GRP_NRM = 3'd2,
      GRP_VEL = 3'd3,
      GRP_ROT = 3'd4
   } group_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // Applies a sign to a magnitude and saturates to the 16 bit signed range.
   function automatic logic signed [15:0] sat_mag16(input logic neg, input logic [63:0] q);
      logic signed [16:0] t;
      t = '0;
      if (neg) begin
         if (q > 64'd32768) t = -17'sd32768;
         else t = -$signed({1'b0, q[15:0]});
      end else if (q > 64'd32767) begin
         t = 17'sd32767;
      end else begin
         t = $signed({1'b0, q[15:0]});
      end
      return t[15:0];
   endfunction

   // Divide by 2^sh, rounding halves away from zero, then saturate.
   function automatic logic signed [15:0] rnd_shift_sat(input logic signed [63:0] v,
                                                       input int unsigned sh);
      logic [63:0] m;
      logic [63:0] q;
      m = mag64(v) + (64'd1 << (sh - 1));
      q = m >> sh;
      return sat_mag16(v[63], q);
   endfunction

endpackage

// File: sv/gdfv_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Uses widths from gdfv_pkg.
module gdfv_mul (
   input  logic                                   clock,
   input  logic signed [gdfv_pkg::MUL_A_W-1:0]    a,
   input  logic signed [gdfv_pkg::MUL_B_W-1:0]    b,
   output logic signed [gdfv_pkg::PROD_W-1:0]     prod
);

   logic signed [gdfv_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule

// File: sv/gdfv_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Uses widths and the status struct from gdfv_pkg.
module gdfv_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [gdfv_pkg::WORD_W-1:0]        dividend,
   input  logic [gdfv_pkg::WORD_W-1:0]        divisor,
   output logic [gdfv_pkg::WORD_W-1:0]        quotient,
   output gdfv_pkg::unit_status_type          status
);

   localparam int CNT_W = $clog2(gdfv_pkg::WORD_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [gdfv_pkg::WORD_W-1:0] rem_ff, rem_in;
   logic [gdfv_pkg::WORD_W-1:0] quo_ff, quo_in;
   logic [gdfv_pkg::WORD_W-1:0] dvs_ff, dvs_in;
   logic [gdfv_pkg::WORD_W:0]   shifted;
   logic                        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[gdfv_pkg::WORD_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(gdfv_pkg::WORD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? gdfv_pkg::WORD_W'(shifted - {1'b0, dvs_ff})
                     : shifted[gdfv_pkg::WORD_W-1:0];
         quo_in = {quo_ff[gdfv_pkg::WORD_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: sv/gdfv_isqrt.sv
`timescale 1ns / 1ps
// Iterative integer square root (floor), one result bit per cycle.
// Uses widths and the status struct from gdfv_pkg.
module gdfv_isqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [gdfv_pkg::SQ_IN_W-1:0]        radicand,
   output logic [gdfv_pkg::SQ_OUT_W-1:0]       root,
   output gdfv_pkg::unit_status_type           status
);

   localparam logic [gdfv_pkg::SQ_IN_W-1:0] BIT_START =
      gdfv_pkg::SQ_IN_W'(1) << (gdfv_pkg::SQ_IN_W - 2);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [gdfv_pkg::SQ_IN_W-1:0] n_ff, n_in;
   logic [gdfv_pkg::SQ_IN_W-1:0] res_ff, res_in;
   logic [gdfv_pkg::SQ_IN_W-1:0] bit_ff, bit_in;
   logic [gdfv_pkg::SQ_IN_W:0]   trial;

   always_comb begin
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         n_in    = radicand;
         res_in  = '0;
         bit_in  = BIT_START;
      end else if (busy_ff) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in   = gdfv_pkg::SQ_IN_W'({1'b0, n_ff} - trial);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == gdfv_pkg::SQ_IN_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root        = res_ff[gdfv_pkg::SQ_OUT_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: sv/gated_direction_filter_velocity.sv
`timescale 1ns / 1ps
// Top level: sequencer of the gated direction filter and its velocity output.
// Depends on gdfv_pkg, gdfv_mul, gdfv_div and gdfv_isqrt.

// One sample is taken at a time and the block stalls its input until the result
// has moved into the output register. Every product goes through one shared
// multiplier and every quotient through one divider that yields a bit per cycle.
// An accepted sample adds a square root and, unless the root is zero, three
// renormalizing divisions to the work of a first or rejected sample, and a zero
// quaternion skips the rotation products and both velocity divisions.
// The gain register may be written in any cycle while no sample is in work;
// csr_ready is always high.
module gated_direction_filter_velocity #(
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_raw_dir_x,
   input  logic signed [15:0] req_raw_dir_y,
   input  logic signed [15:0] req_raw_dir_z,
   input  logic signed [15:0] req_speed,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_filtered_x,
   output logic signed [15:0] rsp_filtered_y,
   output logic signed [15:0] rsp_filtered_z,
   output logic               rsp_accepted,
   output logic [7:0]         rsp_reject_run,
   output logic signed [15:0] rsp_vel_north,
   output logic signed [15:0] rsp_vel_east
);

   localparam logic [63:0] UNIT = 64'd1 << DIR_FRAC_BITS;
   localparam logic signed [15:0] SMOOTH_Z_RESET = gdfv_pkg::sat_mag16(1'b0, UNIT);
   localparam int QP_N = 10;

   gdfv_pkg::state_type state_ff, state_in;
   gdfv_pkg::group_type grp_ff, grp_in;
   logic [3:0]          idx_ff, idx_in;
   logic                go_ff, go_in;

   logic [15:0]         gain_ff, gain_in;
   logic signed [15:0]  smooth_x_ff, smooth_x_in, smooth_y_ff, smooth_y_in;
   logic signed [15:0]  smooth_z_ff, smooth_z_in;
   logic                primed_ff, primed_in;
   logic [7:0]          rej_ff, rej_in;
   logic                acc_flag_ff, acc_flag_in;

   logic signed [15:0]  raw_x_ff, raw_x_in, raw_y_ff, raw_y_in, raw_z_ff, raw_z_in;
   logic signed [15:0]  spd_ff, spd_in;
   logic signed [15:0]  quat_w_ff, quat_w_in, quat_x_ff, quat_x_in;
   logic signed [15:0]  quat_y_ff, quat_y_in, quat_z_ff, quat_z_in;
   logic signed [15:0]  f_x_ff, f_x_in, f_y_ff, f_y_in, f_z_ff, f_z_in;
   logic [15:0]         norm_ff, norm_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic signed [31:0]  v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic signed [31:0]  qp_ff [QP_N];
   logic signed [31:0]  qp_in [QP_N];
   logic signed [63:0]  sn_ff, sn_in, se_ff, se_in;
   logic signed [15:0]  vn_ff, vn_in, ve_ff, ve_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  rsp_fx_ff, rsp_fy_ff, rsp_fz_ff, rsp_vn_ff, rsp_ve_ff;
   logic                rsp_acc_ff;
   logic [7:0]          rsp_rej_ff;
   logic                rsp_load;

   logic signed [gdfv_pkg::MUL_A_W-1:0] mul_a;
   logic signed [gdfv_pkg::MUL_B_W-1:0] mul_b;
   logic signed [gdfv_pkg::PROD_W-1:0]  mul_prod;
   logic signed [63:0]  p64, base, sum;
   logic                first_term;

   logic [1:0]          comp;
   logic signed [15:0]  sel_raw, sel_smooth, sel_f;
   logic signed [33:0]  c00, c01, c02, c10, c11, c12;
   logic [32:0]         qs;
   logic [63:0]         den;

   logic                sqrt_start;
   logic [15:0]         sqrt_root;
   gdfv_pkg::unit_status_type sq_status;
   logic                div_start;
   logic [63:0]         div_num, div_dvs, div_q;
   logic                div_neg;
   gdfv_pkg::unit_status_type div_status;
   logic signed [15:0]  div_val;

   gdfv_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   gdfv_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum[31:0]),
      .root     (sqrt_root),
      .status   (sq_status)
   );

   gdfv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_dvs),
      .quotient (div_q),
      .status   (div_status)
   );

   assign csr_ready = 1'b1;
   assign req_stall = state_ff != gdfv_pkg::ST_IDLE;

   // Component selection and the rotation coefficients.
   always_comb begin
      comp = (grp_ff == gdfv_pkg::GRP_EMA) ? idx_ff[2:1] : idx_ff[1:0];
      case (comp)
         2'd0:    begin sel_raw = raw_x_ff; sel_smooth = smooth_x_ff; sel_f = f_x_ff; end
         2'd1:    begin sel_raw = raw_y_ff; sel_smooth = smooth_y_ff; sel_f = f_y_ff; end
         default: begin sel_raw = raw_z_ff; sel_smooth = smooth_z_ff; sel_f = f_z_ff; end
      endcase
      // Product order: ww xx yy zz xy wz xz wy yz wx.
      c00 = 34'(qp_ff[0]) + 34'(qp_ff[1]) - 34'(qp_ff[2]) - 34'(qp_ff[3]);
      c01 = (34'(qp_ff[4]) - 34'(qp_ff[5])) <<< 1;
      c02 = (34'(qp_ff[6]) + 34'(qp_ff[7])) <<< 1;
      c10 = (34'(qp_ff[4]) + 34'(qp_ff[5])) <<< 1;
      c11 = 34'(qp_ff[0]) - 34'(qp_ff[1]) + 34'(qp_ff[2]) - 34'(qp_ff[3]);
      c12 = (34'(qp_ff[8]) - 34'(qp_ff[9])) <<< 1;
      qs  = {1'b0, qp_ff[0]} + {1'b0, qp_ff[1]} + {1'b0, qp_ff[2]} + {1'b0, qp_ff[3]};
      den = 64'(qs) << DIR_FRAC_BITS;
   end

   // Multiplier operands.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (grp_ff)
         gdfv_pkg::GRP_DOT: begin
            mul_a = 34'(sel_raw);
            mul_b = 32'(sel_smooth);
         end
         gdfv_pkg::GRP_EMA: begin
            if (!idx_ff[0]) begin
               mul_a = 34'(gain_ff);
               mul_b = 32'(sel_raw);
            end else begin
               mul_a = 34'(17'h10000) - 34'(gain_ff);
               mul_b = 32'(sel_smooth);
            end
         end
         gdfv_pkg::GRP_NRM: begin
            mul_a = 34'(sel_f);
            mul_b = 32'(sel_f);
         end
         gdfv_pkg::GRP_VEL: begin
            case (idx_ff)
               4'd0, 4'd1, 4'd2: begin mul_a = 34'(spd_ff); mul_b = 32'(sel_smooth); end
               4'd3:    begin mul_a = 34'(quat_w_ff); mul_b = 32'(quat_w_ff); end
               4'd4:    begin mul_a = 34'(quat_x_ff); mul_b = 32'(quat_x_ff); end
               4'd5:    begin mul_a = 34'(quat_y_ff); mul_b = 32'(quat_y_ff); end
               4'd6:    begin mul_a = 34'(quat_z_ff); mul_b = 32'(quat_z_ff); end
               4'd7:    begin mul_a = 34'(quat_x_ff); mul_b = 32'(quat_y_ff); end
               4'd8:    begin mul_a = 34'(quat_w_ff); mul_b = 32'(quat_z_ff); end
               4'd9:    begin mul_a = 34'(quat_x_ff); mul_b = 32'(quat_z_ff); end
               4'd10:   begin mul_a = 34'(quat_w_ff); mul_b = 32'(quat_y_ff); end
               4'd11:   begin mul_a = 34'(quat_y_ff); mul_b = 32'(quat_z_ff); end
               default: begin mul_a = 34'(quat_w_ff); mul_b = 32'(quat_x_ff); end
            endcase
         end
         gdfv_pkg::GRP_ROT: begin
            case (idx_ff)
               4'd0:    begin mul_a = c00; mul_b = v0_ff; end
               4'd1:    begin mul_a = c01; mul_b = v1_ff; end
               4'd2:    begin mul_a = c02; mul_b = v2_ff; end
               4'd3:    begin mul_a = c10; mul_b = v0_ff; end
               4'd4:    begin mul_a = c11; mul_b = v1_ff; end
               default: begin mul_a = c12; mul_b = v2_ff; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Divider operands and the signed, limited quotient.
   always_comb begin
      if (grp_ff == gdfv_pkg::GRP_NRM) begin
         div_neg = sel_f[15];
         div_num = (gdfv_pkg::mag64(64'(sel_f)) << DIR_FRAC_BITS) + 64'(norm_ff[15:1]);
         div_dvs = 64'(norm_ff);
         div_val = gdfv_pkg::sat_mag16(div_neg, (div_q > UNIT) ? UNIT : div_q);
      end else begin
         div_neg = idx_ff[0] ? se_ff[63] : sn_ff[63];
         div_num = gdfv_pkg::mag64(idx_ff[0] ? se_ff : sn_ff) + (den >> 1);
         div_dvs = den;
         div_val = gdfv_pkg::sat_mag16(div_neg, div_q);
      end
   end

   assign p64        = mul_prod[63:0];
   assign first_term = (idx_ff == 4'd0) ||
                       (grp_ff == gdfv_pkg::GRP_EMA && !idx_ff[0]) ||
                       (grp_ff == gdfv_pkg::GRP_ROT && idx_ff == 4'd3);
   assign base       = first_term ? 64'sd0 : acc_ff;
   assign sum        = base + p64;

   always_comb begin
      state_in    = state_ff;
      grp_in      = grp_ff;
      idx_in      = idx_ff;
      go_in       = go_ff;
      gain_in     = csr_valid ? csr_data : gain_ff;
      smooth_x_in = smooth_x_ff;
      smooth_y_in = smooth_y_ff;
      smooth_z_in = smooth_z_ff;
      primed_in   = primed_ff;
      rej_in      = rej_ff;
      acc_flag_in = acc_flag_ff;
      raw_x_in    = raw_x_ff;
      raw_y_in    = raw_y_ff;
      raw_z_in    = raw_z_ff;
      spd_in      = spd_ff;
      quat_w_in   = quat_w_ff;
      quat_x_in   = quat_x_ff;
      quat_y_in   = quat_y_ff;
      quat_z_in   = quat_z_ff;
      f_x_in      = f_x_ff;
      f_y_in      = f_y_ff;
      f_z_in      = f_z_ff;
      norm_in     = norm_ff;
      acc_in      = acc_ff;
      v0_in       = v0_ff;
      v1_in       = v1_ff;
      v2_in       = v2_ff;
      qp_in       = qp_ff;
      sn_in       = sn_ff;
      se_in       = se_ff;
      vn_in       = vn_ff;
      ve_in       = ve_ff;
      sqrt_start  = 1'b0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         gdfv_pkg::ST_IDLE: begin
            if (req_valid) begin
               raw_x_in    = req_raw_dir_x;
               raw_y_in    = req_raw_dir_y;
               raw_z_in    = req_raw_dir_z;
               spd_in      = req_speed;
               quat_w_in   = req_quat_w;
               quat_x_in   = req_quat_x;
               quat_y_in   = req_quat_y;
               quat_z_in   = req_quat_z;
               acc_flag_in = 1'b1;
               idx_in      = '0;
               state_in    = gdfv_pkg::ST_MUL;
               if (!primed_ff) begin
                  smooth_x_in = req_raw_dir_x;
                  smooth_y_in = req_raw_dir_y;
                  smooth_z_in = req_raw_dir_z;
                  primed_in   = 1'b1;
                  grp_in      = gdfv_pkg::GRP_VEL;
               end else begin
                  grp_in = gdfv_pkg::GRP_DOT;
               end
            end
         end
         gdfv_pkg::ST_MUL: begin
            // A zero quaternion skips the rotation entirely.
            if (grp_ff == gdfv_pkg::GRP_ROT && idx_ff == 4'd0 && qs == 33'd0) begin
               vn_in    = gdfv_pkg::rnd_shift_sat(64'(v0_ff), DIR_FRAC_BITS);
               ve_in    = gdfv_pkg::rnd_shift_sat(64'(v1_ff), DIR_FRAC_BITS);
               state_in = gdfv_pkg::ST_FIN;
            end else begin
               state_in = gdfv_pkg::ST_ACC;
            end
         end
         gdfv_pkg::ST_ACC: begin
            acc_in   = sum;
            state_in = gdfv_pkg::ST_MUL;
            idx_in   = idx_ff + 4'd1;
            case (grp_ff)
               gdfv_pkg::GRP_DOT: begin
                  if (idx_ff == 4'd2) begin
                     idx_in = '0;
                     if (sum > 64'sd0) begin
                        grp_in = gdfv_pkg::GRP_EMA;
                     end else begin
                        acc_flag_in = 1'b0;
                        if (rej_ff != gdfv_pkg::REJECT_MAX) rej_in = rej_ff + 8'd1;
                        grp_in = gdfv_pkg::GRP_VEL;
                     end
                  end
               end
               gdfv_pkg::GRP_EMA: begin
                  if (idx_ff[0]) begin
                     case (idx_ff[2:1])
                        2'd0:    f_x_in = gdfv_pkg::rnd_shift_sat(sum, gdfv_pkg::EMA_SHIFT);
                        2'd1:    f_y_in = gdfv_pkg::rnd_shift_sat(sum, gdfv_pkg::EMA_SHIFT);
                        default: f_z_in = gdfv_pkg::rnd_shift_sat(sum, gdfv_pkg::EMA_SHIFT);
                     endcase
                  end
                  if (idx_ff == 4'd5) begin
                     idx_in = '0;
                     grp_in = gdfv_pkg::GRP_NRM;
                  end
               end
               gdfv_pkg::GRP_NRM: begin
                  if (idx_ff == 4'd2) begin
                     idx_in     = '0;
                     sqrt_start = 1'b1;
                     state_in   = gdfv_pkg::ST_SQRT;
                  end
               end
               gdfv_pkg::GRP_VEL: begin
                  case (idx_ff)
                     4'd0:    v0_in = p64[31:0];
                     4'd1:    v1_in = -p64[31:0];
                     4'd2:    v2_in = -p64[31:0];
                     default: qp_in[4'(idx_ff - 4'd3)] = p64[31:0];
                  endcase
                  if (idx_ff == 4'd12) begin
                     idx_in = '0;
                     grp_in = gdfv_pkg::GRP_ROT;
                  end
               end
               gdfv_pkg::GRP_ROT: begin
                  if (idx_ff == 4'd2) sn_in = sum;
                  if (idx_ff == 4'd5) begin
                     se_in    = sum;
                     idx_in   = '0;
                     go_in    = 1'b1;
                     state_in = gdfv_pkg::ST_DIV;
                  end
               end
               default: state_in = gdfv_pkg::ST_IDLE;
            endcase
         end
         gdfv_pkg::ST_SQRT: begin
            if (sq_status.done) begin
               if (sqrt_root == 16'd0) begin
                  smooth_x_in = f_x_ff;
                  smooth_y_in = f_y_ff;
                  smooth_z_in = f_z_ff;
                  rej_in      = '0;
                  grp_in      = gdfv_pkg::GRP_VEL;
                  idx_in      = '0;
                  state_in    = gdfv_pkg::ST_MUL;
               end else begin
                  norm_in  = sqrt_root;
                  idx_in   = '0;
                  go_in    = 1'b1;
                  state_in = gdfv_pkg::ST_DIV;
               end
            end
         end
         gdfv_pkg::ST_DIV: begin
            if (go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b0;
            end else if (div_status.done) begin
               if (grp_ff == gdfv_pkg::GRP_NRM) begin
                  case (idx_ff[1:0])
                     2'd0:    f_x_in = div_val;
                     2'd1:    f_y_in = div_val;
                     default: f_z_in = div_val;
                  endcase
                  if (idx_ff == 4'd2) begin
                     smooth_x_in = f_x_ff;
                     smooth_y_in = f_y_ff;
                     smooth_z_in = div_val;
                     rej_in      = '0;
                     grp_in      = gdfv_pkg::GRP_VEL;
                     idx_in      = '0;
                     state_in    = gdfv_pkg::ST_MUL;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                     go_in  = 1'b1;
                  end
               end else begin
                  if (idx_ff == 4'd0) begin
                     vn_in  = div_val;
                     idx_in = 4'd1;
                     go_in  = 1'b1;
                  end else begin
                     ve_in    = div_val;
                     state_in = gdfv_pkg::ST_FIN;
                  end
               end
            end
         end
         gdfv_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = gdfv_pkg::ST_IDLE;
            end
         end
         default: state_in = gdfv_pkg::ST_IDLE;
      endcase

      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdfv_pkg::ST_IDLE;
         grp_ff       <= gdfv_pkg::GRP_DOT;
         idx_ff       <= '0;
         go_ff        <= 1'b0;
         gain_ff      <= gdfv_pkg::GAIN_RESET;
         smooth_x_ff  <= '0;
         smooth_y_ff  <= '0;
         smooth_z_ff  <= SMOOTH_Z_RESET;
         primed_ff    <= 1'b0;
         rej_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grp_ff       <= grp_in;
         idx_ff       <= idx_in;
         go_ff        <= go_in;
         gain_ff      <= gain_in;
         smooth_x_ff  <= smooth_x_in;
         smooth_y_ff  <= smooth_y_in;
         smooth_z_ff  <= smooth_z_in;
         primed_ff    <= primed_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_flag_ff <= acc_flag_in;
      raw_x_ff    <= raw_x_in;
      raw_y_ff    <= raw_y_in;
      raw_z_ff    <= raw_z_in;
      spd_ff      <= spd_in;
      quat_w_ff   <= quat_w_in;
      quat_x_ff   <= quat_x_in;
      quat_y_ff   <= quat_y_in;
      quat_z_ff   <= quat_z_in;
      f_x_ff      <= f_x_in;
      f_y_ff      <= f_y_in;
      f_z_ff      <= f_z_in;
      norm_ff     <= norm_in;
      acc_ff      <= acc_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      qp_ff       <= qp_in;
      sn_ff       <= sn_in;
      se_ff       <= se_in;
      vn_ff       <= vn_in;
      ve_ff       <= ve_in;
      if (rsp_load) begin
         rsp_fx_ff  <= smooth_x_ff;
         rsp_fy_ff  <= smooth_y_ff;
         rsp_fz_ff  <= smooth_z_ff;
         rsp_acc_ff <= acc_flag_ff;
         rsp_rej_ff <= rej_ff;
         rsp_vn_ff  <= vn_ff;
         rsp_ve_ff  <= ve_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered_x = rsp_fx_ff;
   assign rsp_filtered_y = rsp_fy_ff;
   assign rsp_filtered_z = rsp_fz_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_reject_run = rsp_rej_ff;
   assign rsp_vel_north  = rsp_vn_ff;
   assign rsp_vel_east   = rsp_ve_ff;

   // The rejection run only clears or counts up by one.
   a_rej_step: assert property (@(posedge clock) disable iff (reset)
      (rej_ff != $past(rej_ff)) |-> (rej_ff == 8'd0 || rej_ff == $past(rej_ff) + 8'd1))
      else $error("rejection run changed by more than one step");

   // A rejected beat always carries a nonzero run.
   a_rej_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !acc_flag_ff) |-> (rej_ff != 8'd0))
      else $error("rejected beat with zero run");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == gdfv_pkg::ST_DIV))
      else $error("divider running outside the divide step");

   a_sqrt_owner: assert property (@(posedge clock) disable iff (reset)
      sq_status.busy |-> (state_ff == gdfv_pkg::ST_SQRT))
      else $error("square root running outside its step");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the gated direction filter with velocity output.
// Needs gdfv_pkg and gated_direction_filter_velocity; predicts every result beat.
module tb_top;

   localparam int UNIT = 1 << 14;
   localparam longint LIMIT = 3000000;
   localparam int RAND_PER_PHASE = 308;

   typedef struct {
      logic signed [15:0] rx, ry, rz, spd, qw, qx, qy, qz;
   } sample_type;

   typedef struct {
      logic signed [15:0] fx, fy, fz;
      logic               acc;
      logic [7:0]         run;
      logic signed [15:0] vn, ve;
   } filt_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [15:0] csr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_raw_dir_x = '0, req_raw_dir_y = '0, req_raw_dir_z = '0;
   logic signed [15:0] req_speed = '0, req_quat_w = '0, req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_filtered_x, rsp_filtered_y, rsp_filtered_z;
   logic rsp_accepted;
   logic [7:0] rsp_reject_run;
   logic signed [15:0] rsp_vel_north, rsp_vel_east;

   gated_direction_filter_velocity DUT (.*);

   always #2 clock = ~clock;

   // Predictor state.
   longint gain_m;
   longint sx, sy, sz;
   bit primed_m;
   int rej_m;

   sample_type pending_q[$];
   filt_type   expected_q[$];
   int errors = 0;
   int send_idle = 0, recv_stall = 0;
   bit holdoff_go = 0;
   bit holdoff_used = 0;
   int holdoff_cnt = 0;
   longint cycles = 0;
   int n_acc = 0, n_rej = 0, n_beats = 0;

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint div_rnd(longint num, longint den);
      longint unsigned m;
      longint unsigned q;
      m = (num < 0) ? -num : num;
      q = (m + 64'(den) / 2) / 64'(den);
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint root_floor(longint n);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > UNIT) v = UNIT;
      if (v < -UNIT) v = -UNIT;
      return sat16(v);
   endfunction

   function automatic filt_type filter_step(sample_type s);
      filt_type r;
      longint rx, ry, rz, sp, w, x, y, z, dot, a, b, fx, fy, fz, nrm;
      longint vx, vy, vz, q2, c00, c01, c02, c10, c11, c12, vn, ve;
      rx = s.rx; ry = s.ry; rz = s.rz; sp = s.spd;
      w = s.qw; x = s.qx; y = s.qy; z = s.qz;
      r.acc = 1;
      if (!primed_m) begin
         sx = rx; sy = ry; sz = rz; primed_m = 1;
      end else begin
         dot = rx * sx + ry * sy + rz * sz;
         if (dot > 0) begin
            a = gain_m; b = 65536 - a;
            fx = sat16(div_rnd(a * rx + b * sx, 65536));
            fy = sat16(div_rnd(a * ry + b * sy, 65536));
            fz = sat16(div_rnd(a * rz + b * sz, 65536));
            nrm = root_floor(fx * fx + fy * fy + fz * fz);
            if (nrm > 0) begin
               fx = clamp_unit(div_rnd(fx * UNIT, nrm));
               fy = clamp_unit(div_rnd(fy * UNIT, nrm));
               fz = clamp_unit(div_rnd(fz * UNIT, nrm));
            end
            sx = fx; sy = fy; sz = fz; rej_m = 0;
         end else begin
            r.acc = 0;
            if (rej_m < 255) rej_m++;
         end
      end
      vx = sp * sx; vy = -(sp * sy); vz = -(sp * sz);
      q2 = w * w + x * x + y * y + z * z;
      if (q2 == 0) begin
         vn = div_rnd(vx, UNIT);
         ve = div_rnd(vy, UNIT);
      end else begin
         c00 = w * w + x * x - y * y - z * z;
         c01 = 2 * (x * y - w * z);
         c02 = 2 * (x * z + w * y);
         c10 = 2 * (x * y + w * z);
         c11 = w * w - x * x + y * y - z * z;
         c12 = 2 * (y * z - w * x);
         vn = div_rnd(c00 * vx + c01 * vy + c02 * vz, q2 * UNIT);
         ve = div_rnd(c10 * vx + c11 * vy + c12 * vz, q2 * UNIT);
      end
      r.fx = sx[15:0]; r.fy = sy[15:0]; r.fz = sz[15:0];
      r.run = rej_m[7:0];
      r.vn = 16'(sat16(vn)); r.ve = 16'(sat16(ve));
      return r;
   endfunction

   function automatic logic signed [15:0] rand_unit_field();
      case ($urandom_range(0, 9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // Roughly unit vector near a base direction, so most samples pass the gate.
   function automatic sample_type rand_sample(int mode);
      sample_type s;
      int d;
      d = (mode == 0) ? 3000 : 16384;
      s.rx = 16'(sx + $signed($urandom_range(0, 2 * d)) - d);
      s.ry = 16'(sy + $signed($urandom_range(0, 2 * d)) - d);
      s.rz = 16'(sz + $signed($urandom_range(0, 2 * d)) - d);
      if (mode == 2) begin
         s.rx = -s.rx; s.ry = -s.ry; s.rz = -s.rz;
      end
      if (mode == 3) begin
         s.rx = rand_unit_field(); s.ry = rand_unit_field(); s.rz = rand_unit_field();
      end
      s.spd = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                          : 16'($signed($urandom_range(0, 8000)) - 4000);
      if ($urandom_range(0, 19) == 0) begin
         s.qw = '0; s.qx = '0; s.qy = '0; s.qz = '0;
      end else begin
         s.qw = rand_unit_field(); s.qx = rand_unit_field();
         s.qy = rand_unit_field(); s.qz = rand_unit_field();
      end
      return s;
   endfunction

   function automatic sample_type mk(int rx, int ry, int rz, int sp, int w, int x, int y,
                                     int z);
      sample_type s;
      s.rx = 16'(rx); s.ry = 16'(ry); s.rz = 16'(rz); s.spd = 16'(sp);
      s.qw = 16'(w); s.qx = 16'(x); s.qy = 16'(y); s.qz = 16'(z);
      return s;
   endfunction

   // Driver: a beat is predicted when it is accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            filt_type f;
            f = filter_step(pending_q.pop_front());
            if (f.acc) n_acc++;
            else n_rej++;
            expected_q.push_back(f);
         end
         if (!(req_valid && req_stall)) begin
            if (pending_q.size() > 0 && ($urandom_range(0, 99) >= send_idle)) begin
               req_valid <= 1;
               req_raw_dir_x <= pending_q[0].rx; req_raw_dir_y <= pending_q[0].ry;
               req_raw_dir_z <= pending_q[0].rz; req_speed <= pending_q[0].spd;
               req_quat_w <= pending_q[0].qw; req_quat_x <= pending_q[0].qx;
               req_quat_y <= pending_q[0].qy; req_quat_z <= pending_q[0].qz;
            end else req_valid <= 0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_beats++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, actual x=%0d", $time, rsp_filtered_x);
            end else begin
               filt_type e;
               e = expected_q.pop_front();
               if ({rsp_filtered_x, rsp_filtered_y, rsp_filtered_z, rsp_accepted,
                    rsp_reject_run, rsp_vel_north, rsp_vel_east} !==
                   {e.fx, e.fy, e.fz, e.acc, e.run, e.vn, e.ve}) begin
                  errors++;
                  $display("%0t: mismatch expected f=(%0d %0d %0d) acc=%0d run=%0d v=(%0d %0d)",
                           $time, e.fx, e.fy, e.fz, e.acc, e.run, e.vn, e.ve);
                  $display("%0t:          actual f=(%0d %0d %0d) acc=%0d run=%0d v=(%0d %0d)",
                           $time, rsp_filtered_x, rsp_filtered_y, rsp_filtered_z,
                           rsp_accepted, rsp_reject_run, rsp_vel_north, rsp_vel_east);
               end
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (!reset) begin
         if (holdoff_go && !holdoff_used) begin
            holdoff_used <= 1;
            holdoff_cnt  <= 3000;
            rsp_stall    <= 1;
         end else if (holdoff_cnt > 0) begin
            holdoff_cnt <= holdoff_cnt - 1;
            rsp_stall   <= 1;
         end else rsp_stall <= ($urandom_range(0, 99) < recv_stall);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic drain();
      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic set_gain(logic [15:0] g);
      @(posedge clock);
      csr_valid <= 1;
      csr_data <= g;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      gain_m = g;
   endtask

   initial begin
      int phase;
      logic [15:0] gains [5];
      gains = '{16'd0, 16'd65535, 16'd9830, 16'd32768, 16'd1};
      gain_m = 9830; sx = 0; sy = 0; sz = UNIT; primed_m = 0; rej_m = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      // Directed: first sample, zero dot, reverse, extremes, zero quaternion.
      pending_q.push_back(mk(16384, 0, 0, 32767, 16384, 0, 0, 0));
      pending_q.push_back(mk(0, 16384, 0, -32768, 0, 0, 0, 0));
      pending_q.push_back(mk(-16384, 0, 0, 256, 16384, 16384, 16384, 16384));
      pending_q.push_back(mk(-32768, -32768, -32768, 1000, -16384, 0, 0, 0));
      pending_q.push_back(mk(16384, 16384, 16384, 32767, 0, 16384, 0, 0));
      pending_q.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
      pending_q.push_back(mk(16384, 0, 0, -256, 0, 0, 0, 16384));
      pending_q.push_back(mk(0, 0, 0, 5000, 0, 0, -16384, 0));
      drain();
      set_gain(16'd0);
      // EMA with gain zero: the direction only gets renormalized.
      pending_q.push_back(mk(16000, 3000, 0, 4000, 16384, 0, 0, 0));
      drain();
      // Half gain toward a nearby direction, then an opposite one that is rejected.
      set_gain(16'd32768);
      pending_q.push_back(mk(16384, 0, 0, 100, 16384, 0, 0, 0));
      pending_q.push_back(mk(-16383, 1, 0, 100, 16384, 0, 0, 0));
      drain();
      // 300 rejections in a row saturate the counter.
      for (int i = 0; i < 300; i++) pending_q.push_back(mk(0, 0, 0, 1, 0, 0, 0, 0));
      drain();
      for (phase = 0; phase < 5; phase++) begin
         set_gain(gains[phase]);
         send_idle  = (phase == 1 || phase == 3) ? 61 : (phase == 4 ? 16 : 0);
         recv_stall = (phase == 2 || phase == 3) ? 61 : (phase == 4 ? 16 : 0);
         if (phase == 0) holdoff_go = 1;
         for (int i = 0; i < RAND_PER_PHASE; i++) begin
            int r;
            r = $urandom_range(0, 99);
            pending_q.push_back(rand_sample(r < 70 ? 0 : (r < 80 ? 1 : (r < 90 ? 2 : 3))));
            while (pending_q.size() > 4) @(posedge clock);
         end
         drain();
      end
      $display("Covered %0d result beats: %0d accepted, %0d rejected, five gain settings.",
               n_beats, n_acc, n_rej);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
